FILE: sv/fba_pkg.sv
// Shared constants, codes and control types of the frame bitmap allocator.
// No dependencies; every other file refers to it by scoped names or imports it.
package fba_pkg;

  // Bitmap geometry. MAP_WORD_BITS must be a power of two.
  localparam int FRAME_COUNT   = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_DEPTH     = (FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  // Frame field of the request and result channels.
  localparam int FRAME_W    = 12;
  localparam int FRAME_SPAN = 1 << FRAME_W;

  // Frames at or above this limit are never handed out.
  localparam int ALLOC_LIMIT = (FRAME_COUNT < FRAME_SPAN) ? FRAME_COUNT : FRAME_SPAN;

  localparam int BIT_W  = $clog2(MAP_WORD_BITS);
  localparam int ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int IDX_W  = ADDR_W + BIT_W;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_IDLE = 2'd1,
    ST_FULL = 2'd2
  } fba_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN,
    S_PICK,
    S_RESP
  } fba_state_e;

  typedef struct packed {
    fba_status_e          status;
    logic [FRAME_W-1:0]   frame;
    logic                 present;
    logic                 writable;
    logic                 user;
  } fba_res_t;

  // Controller -> datapath
  typedef struct packed {
    logic in_ready;    // take a request
    logic rd_free;     // read the word of the frame being freed
    logic wr_free;     // write it back with the bit cleared
    logic scan;        // advance the bitmap scan
    logic latch_word;  // hold the first word with a free bit
    logic pick;        // choose the bit, mark it, build the result
    logic set_full;    // no free frame
    logic out_load;    // move the result to the output register
  } fba_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic req_valid;
    logic req_free;
    logic req_present;
    logic hit;         // checked word has a free bit
    logic scan_end;    // last word checked and full
    logic out_busy;    // output register still held by the sink
  } fba_sts_t;

endpackage

FILE: sv/fba_req_if.sv
// Request channel of the frame bitmap allocator.
// Depends on fba_pkg for the frame field width.
interface fba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic                        entry_present;
  logic [fba_pkg::FRAME_W-1:0] frame_number;
  logic                        kernel_page;
  logic                        write_allowed;

  modport source (
    output valid, req_type, entry_present, frame_number, kernel_page, write_allowed,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_present, frame_number, kernel_page, write_allowed,
    output ready
  );
endinterface

FILE: sv/fba_rsp_if.sv
// Result channel of the frame bitmap allocator.
// Depends on fba_pkg for the status code and frame field width.
interface fba_rsp_if;
  logic                        valid;
  logic                        ready;
  fba_pkg::fba_status_e        status;
  logic [fba_pkg::FRAME_W-1:0] frame_out;
  logic                        present_out;
  logic                        writable_out;
  logic                        user_out;

  modport source (
    output valid, status, frame_out, present_out, writable_out, user_out,
    input  ready
  );
  modport sink (
    input  valid, status, frame_out, present_out, writable_out, user_out,
    output ready
  );
endinterface

FILE: sv/frame_bitmap_allocator_unit.sv
// Top level of the bitmap first-fit page frame allocator.
// Depends on fba_pkg, fba_req_if, fba_rsp_if, fba_ctrl and fba_datapath.
//
//   channel  modport  direction  payload
//   req_i    sink     in         req_type, entry_present, frame_number,
//                                kernel_page, write_allowed
//   rsp_o    source   out        status, frame_out, present_out,
//                                writable_out, user_out
//
// One request at a time. A free reads the word of its frame and writes it back
// before the result step, and a no-op goes straight to the result step. An
// allocate walks the bitmap one 32-bit word per cycle through the single read
// port of the bitmap memory until it checks a word with a free bit, then picks
// that bit; on a full map it reads and checks all 128 words, then goes to the
// result step. The bitmap reads as all free right after reset (per-row valid
// flops); no clearing pass. The result sits in an output register, so a
// stalled sink holds only the result, and the next request is accepted
// meanwhile; the unit stalls in its result step only if that register is
// still occupied.
module frame_bitmap_allocator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  fba_req_if.sink   req_i,
  fba_rsp_if.source rsp_o
);

  fba_pkg::fba_cmd_t cmd;
  fba_pkg::fba_sts_t sts;

  // sequencing: idle, free read/write, scan, bit pick, result handoff
  fba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // bitmap memory, scan pointer, request/result and output registers
  fba_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

FILE: sv/fba_ctrl.sv
// Sequencing state machine of the frame bitmap allocator.
// Depends on fba_pkg; talks to fba_datapath through fba_cmd_t / fba_sts_t.
module fba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fba_pkg::fba_sts_t sts_i,
  output fba_pkg::fba_cmd_t cmd_o
);

  fba_pkg::fba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fba_pkg::S_IDLE: begin
        if (sts_i.req_valid) begin
          if (sts_i.req_free && sts_i.req_present) begin
            state_d = fba_pkg::S_FREE_RD;
          end else if (!sts_i.req_free && !sts_i.req_present) begin
            state_d = fba_pkg::S_SCAN;
          end else begin
            state_d = fba_pkg::S_RESP;
          end
        end
      end
      fba_pkg::S_FREE_RD: state_d = fba_pkg::S_FREE_WR;
      fba_pkg::S_FREE_WR: state_d = fba_pkg::S_RESP;
      fba_pkg::S_SCAN: begin
        if (sts_i.hit) begin
          state_d = fba_pkg::S_PICK;
        end else if (sts_i.scan_end) begin
          state_d = fba_pkg::S_RESP;
        end
      end
      fba_pkg::S_PICK: state_d = fba_pkg::S_RESP;
      fba_pkg::S_RESP: begin
        if (!sts_i.out_busy) begin
          state_d = fba_pkg::S_IDLE;
        end
      end
      default: state_d = fba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      fba_pkg::S_IDLE:    cmd_o.in_ready = 1'b1;
      fba_pkg::S_FREE_RD: cmd_o.rd_free  = 1'b1;
      fba_pkg::S_FREE_WR: cmd_o.wr_free  = 1'b1;
      fba_pkg::S_SCAN: begin
        cmd_o.scan       = 1'b1;
        cmd_o.latch_word = sts_i.hit;
        cmd_o.set_full   = !sts_i.hit && sts_i.scan_end;
      end
      fba_pkg::S_PICK:    cmd_o.pick     = 1'b1;
      fba_pkg::S_RESP:    cmd_o.out_load = !sts_i.out_busy;
      default:            cmd_o = '0;
    endcase
  end

endmodule

FILE: sv/fba_datapath.sv
// Bitmap memory, scan pointer, request and result registers of the allocator.
// Depends on fba_pkg, fba_req_if and fba_rsp_if; driven by fba_ctrl commands.
module fba_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  fba_req_if.sink           req_i,
  fba_rsp_if.source         rsp_o,
  input  fba_pkg::fba_cmd_t cmd_i,
  output fba_pkg::fba_sts_t sts_o
);

  localparam int WB = fba_pkg::MAP_WORD_BITS;
  localparam int AW = fba_pkg::ADDR_W;
  localparam int BW = fba_pkg::BIT_W;
  localparam int FW = fba_pkg::FRAME_W;

  // bitmap store; a row reads as all free until first written
  logic [WB-1:0]                mem_q [fba_pkg::MAP_DEPTH];
  logic [fba_pkg::MAP_DEPTH-1:0] row_vld_q;

  logic [WB-1:0] rdata_q;
  logic          rvld_q;

  // captured request
  logic          req_kernel_q;
  logic          req_write_q;
  logic [FW-1:0] req_frame_q;

  // scan
  logic [AW:0]   rd_cnt_q;
  logic [AW-1:0] chk_addr_q;
  logic          chk_vld_q;
  logic [WB-1:0] word_q;
  logic [AW-1:0] waddr_q;

  fba_pkg::fba_res_t res_q, out_q;
  logic              out_valid_q;

  logic          accept;
  logic          more_rd;
  logic [WB-1:0] eff_word;
  logic          word_full;
  logic [AW-1:0] free_row;
  logic [BW-1:0] free_bit;
  logic          free_ok;
  logic [WB-1:0] pick_onehot;
  logic [BW-1:0] pick_bit;
  logic [fba_pkg::IDX_W-1:0] pick_frame;
  logic          pick_ok;
  logic          ren;
  logic [AW-1:0] raddr;
  logic          wen;
  logic [AW-1:0] waddr;
  logic [WB-1:0] wdata;

  assign accept    = cmd_i.in_ready && req_i.valid;
  assign more_rd   = rd_cnt_q < (AW + 1)'(fba_pkg::MAP_DEPTH);
  assign eff_word  = rvld_q ? rdata_q : '0;
  assign word_full = (eff_word == '1);

  assign free_row = AW'(req_frame_q >> BW);
  assign free_bit = req_frame_q[BW-1:0];
  assign free_ok  = 32'(req_frame_q) < 32'(fba_pkg::FRAME_COUNT);

  // lowest clear bit of the held word
  assign pick_onehot = ~word_q & (word_q + WB'(1));
  always_comb begin
    pick_bit = '0;
    for (int i = 0; i < WB; i++) begin
      if (pick_onehot[i]) begin
        pick_bit = pick_bit | BW'(i);
      end
    end
  end
  assign pick_frame = {waddr_q, pick_bit};
  assign pick_ok    = 32'(pick_frame) < 32'(fba_pkg::ALLOC_LIMIT);

  assign ren   = cmd_i.rd_free || (cmd_i.scan && more_rd);
  assign raddr = cmd_i.rd_free ? free_row : rd_cnt_q[AW-1:0];
  assign wen   = (cmd_i.wr_free && free_ok) || (cmd_i.pick && pick_ok);
  assign waddr = cmd_i.pick ? waddr_q : free_row;
  assign wdata = cmd_i.pick ? (word_q | pick_onehot) : (eff_word & ~(WB'(1) << free_bit));

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (wen) begin
        row_vld_q[waddr] <= 1'b1;
      end
      if (ren) begin
        rvld_q <= row_vld_q[raddr];
      end
    end
  end

  // scan pointer: issue one read per cycle, check the word read in the cycle before
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
    end else if (accept) begin
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= cmd_i.scan && more_rd;
      if (cmd_i.scan && more_rd) begin
        rd_cnt_q <= rd_cnt_q + (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && more_rd) begin
      chk_addr_q <= rd_cnt_q[AW-1:0];
    end
    if (cmd_i.latch_word) begin
      word_q  <= eff_word;
      waddr_q <= chk_addr_q;
    end
  end

  // request capture and result build
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_kernel_q     <= req_i.kernel_page;
      req_write_q      <= req_i.write_allowed;
      req_frame_q      <= req_i.frame_number;
      res_q.status     <= (req_i.req_type && req_i.entry_present) ? fba_pkg::ST_DONE
                                                                  : fba_pkg::ST_IDLE;
      res_q.frame      <= req_i.frame_number;
      res_q.present    <= !req_i.req_type;
      res_q.writable   <= 1'b0;
      res_q.user       <= 1'b0;
    end else if (cmd_i.set_full || (cmd_i.pick && !pick_ok)) begin
      res_q.status     <= fba_pkg::ST_FULL;
      res_q.frame      <= '0;
      res_q.present    <= 1'b0;
      res_q.writable   <= 1'b0;
      res_q.user       <= 1'b0;
    end else if (cmd_i.pick) begin
      res_q.status     <= fba_pkg::ST_DONE;
      res_q.frame      <= FW'(pick_frame);
      res_q.present    <= 1'b1;
      res_q.writable   <= req_write_q;
      res_q.user       <= !req_kernel_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign req_i.ready        = cmd_i.in_ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.frame_out    = out_q.frame;
  assign rsp_o.present_out  = out_q.present;
  assign rsp_o.writable_out = out_q.writable;
  assign rsp_o.user_out     = out_q.user;

  assign sts_o.req_valid   = req_i.valid;
  assign sts_o.req_free    = req_i.req_type;
  assign sts_o.req_present = req_i.entry_present;
  assign sts_o.hit         = chk_vld_q && !word_full;
  assign sts_o.scan_end    = chk_vld_q && word_full &&
                             (chk_addr_q == AW'(fba_pkg::MAP_DEPTH - 1));
  assign sts_o.out_busy    = out_valid_q && !rsp_o.ready;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !rsp_o.ready))
    else $error("result loaded over a pending result");

  a_pick_after_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> $past(cmd_i.latch_word))
    else $error("pick without a latched word");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_free |-> $past(cmd_i.rd_free))
    else $error("free write without its read");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= (AW + 1)'(fba_pkg::MAP_DEPTH))
    else $error("scan pointer past end of bitmap");

endmodule

FILE: tb/frame_bitmap_allocator_unit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the frame bitmap allocator. It mirrors the frame bitmap,
// predicts the result of each request and checks it on the result channel.
// Depends on fba_pkg, fba_req_if and fba_rsp_if.
module frame_bitmap_allocator_unit_checker
  import fba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fba_req_if          req_i,
  fba_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  logic [MAP_WORD_BITS-1:0] frame_map [MAP_DEPTH] = '{default: '0};
  fba_res_t                 pending_results [$];
  int unsigned              mismatch_count = 0;
  int unsigned              pending_count  = 0;

  assign fail_count_o  = mismatch_count;
  assign outstanding_o = pending_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic void mark_frame(input int unsigned f, input logic used);
    if (f < FRAME_COUNT) begin
      frame_map[f / MAP_WORD_BITS][f % MAP_WORD_BITS] = used;
    end
  endfunction

  // Applies one request to the mirrored bitmap and returns its result.
  function automatic fba_res_t serve_request(input logic is_free, input logic present,
                                             input logic [FRAME_W-1:0] frame,
                                             input logic kernel, input logic writable);
    fba_res_t res;
    int       hole;
    res  = '0;
    hole = -1;
    if (is_free) begin
      res.frame = frame;
      if (present) begin
        res.status = ST_DONE;
        mark_frame(32'(frame), 1'b0);
      end else begin
        res.status = ST_IDLE;
      end
    end else if (present) begin
      res.status  = ST_IDLE;
      res.frame   = frame;
      res.present = 1'b1;
    end else begin
      // first-fit: skip full words, then lowest clear bit
      for (int w = 0; w < MAP_DEPTH && hole < 0; w++) begin
        if (frame_map[w] != '1) begin
          for (int b = 0; b < MAP_WORD_BITS && hole < 0; b++) begin
            if (!frame_map[w][b]) hole = w * MAP_WORD_BITS + b;
          end
        end
      end
      if (hole >= 0 && hole < ALLOC_LIMIT) begin
        mark_frame(32'(hole), 1'b1);
        res.status   = ST_DONE;
        res.frame    = hole[FRAME_W-1:0];
        res.present  = 1'b1;
        res.writable = writable;
        res.user     = !kernel;
      end else begin
        res.status = ST_FULL;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fba_res_t want;
    if (!rst_ni) begin
      foreach (frame_map[i]) frame_map[i] = '0;
      pending_results.delete();
    end else begin
      // result first: a result never belongs to a request taken at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, frame", 32'(rsp_i.frame_out), '0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", 32'(rsp_i.status), 32'(want.status));
          if (rsp_i.frame_out !== want.frame)
            report_mismatch("frame_out", 32'(rsp_i.frame_out), 32'(want.frame));
          if (rsp_i.present_out !== want.present)
            report_mismatch("present_out", 32'(rsp_i.present_out), 32'(want.present));
          if (rsp_i.writable_out !== want.writable)
            report_mismatch("writable_out", 32'(rsp_i.writable_out),
                            32'(want.writable));
          if (rsp_i.user_out !== want.user)
            report_mismatch("user_out", 32'(rsp_i.user_out), 32'(want.user));
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_results.push_back(serve_request(req_i.req_type, req_i.entry_present,
                                                req_i.frame_number, req_i.kernel_page,
                                                req_i.write_allowed));
      end
    end
    pending_count = pending_results.size();
  end

endmodule

FILE: tb/frame_bitmap_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Top of the frame bitmap allocator testbench: clock, reset, request stimulus,
// result-side backpressure and the verdict. Depends on fba_pkg, the channel
// interfaces, frame_bitmap_allocator_unit and frame_bitmap_allocator_unit_checker.
module frame_bitmap_allocator_unit_tb;
  import fba_pkg::*;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Backpressure styles of the result sink.
  typedef enum int unsigned {
    SINK_OPEN,      // always ready
    SINK_COIN,      // ready half of the cycles
    SINK_PERIODIC,  // fixed on/off rhythm
    SINK_RARE       // occasional stalls
  } sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned burst_left = 0;

  fba_req_if req_ch ();
  fba_rsp_if rsp_ch ();

  frame_bitmap_allocator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  frame_bitmap_allocator_unit_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #10 clk_i = ~clk_i;

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  // Result sink: switches at random between the backpressure styles.
  initial begin
    sink_mode_e  mode;
    int unsigned span;
    int unsigned on_len;
    int unsigned off_len;
    rsp_ch.ready <= 1'b0;
    forever begin
      mode    = sink_mode_e'($urandom_range(0, 3));
      span    = $urandom_range(40, 400);
      on_len  = $urandom_range(1, 6);
      off_len = $urandom_range(1, 12);
      for (int c = 0; c < span; c++) begin
        @(posedge clk_i);
        case (mode)
          SINK_OPEN:     rsp_ch.ready <= 1'b1;
          SINK_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
          SINK_PERIODIC: rsp_ch.ready <= (c % (on_len + off_len)) < on_len;
          default:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Presents one request and holds it until taken. Requests go out in bursts;
  // at the end of a burst the channel may go quiet for a random gap.
  task automatic send_req(input logic kind, input logic present,
                          input logic [FRAME_W-1:0] frame,
                          input logic kernel, input logic writable);
    int unsigned gap;
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.entry_present <= present;
    req_ch.frame_number  <= frame;
    req_ch.kernel_page   <= kernel;
    req_ch.write_allowed <= writable;
    do @(posedge clk_i); while (!req_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      // a quarter of the bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // One random request. alloc_pct: alloc of a fresh entry, free_pct: free of a
  // present entry; the rest is no-op traffic (alloc present, free not present).
  // Free targets mostly fall in [0, frame_hi], where frames are likely in use.
  task automatic send_random(input int unsigned alloc_pct, input int unsigned free_pct,
                             input int unsigned frame_hi);
    int unsigned        roll;
    logic [FRAME_W-1:0] frame;
    roll  = $urandom_range(0, 99);
    frame = FRAME_W'($urandom_range(0, FRAME_SPAN - 1));
    if ($urandom_range(0, 7) != 0) frame = FRAME_W'($urandom_range(0, frame_hi));
    if (roll < alloc_pct) begin
      send_req(REQ_ALLOC, 1'b0, FRAME_W'($urandom_range(0, FRAME_SPAN - 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (roll < alloc_pct + free_pct) begin
      send_req(REQ_FREE, 1'b1, frame, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end else if (roll[0]) begin
      send_req(REQ_FREE, 1'b0, frame, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end else begin
      send_req(REQ_ALLOC, 1'b1, frame, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni               <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_ALLOC;
    req_ch.entry_present <= 1'b0;
    req_ch.frame_number  <= '0;
    req_ch.kernel_page   <= 1'b0;
    req_ch.write_allowed <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: first-fit from an empty map, user/writable mapping.
    send_req(REQ_ALLOC, 1'b0, 12'h000, 1'b0, 1'b1);  // frame 0, user, writable
    send_req(REQ_ALLOC, 1'b0, 12'hFFF, 1'b1, 1'b0);  // frame 1, kernel, read-only
    send_req(REQ_ALLOC, 1'b0, 12'hAAA, 1'b1, 1'b1);  // frame 2
    send_req(REQ_ALLOC, 1'b0, 12'h555, 1'b0, 1'b0);  // frame 3
    // alloc on an entry already present: no-op, frame passed through
    send_req(REQ_ALLOC, 1'b1, 12'hFFF, 1'b0, 1'b1);
    send_req(REQ_ALLOC, 1'b1, 12'h000, 1'b1, 1'b0);
    // free of a present entry, then its frame is the lowest hole again
    send_req(REQ_FREE, 1'b1, 12'h001, 1'b1, 1'b1);
    send_req(REQ_ALLOC, 1'b0, 12'h123, 1'b0, 1'b1);
    // free on an entry not present: no-op, bitmap untouched
    send_req(REQ_FREE, 1'b0, 12'h002, 1'b0, 1'b1);
    send_req(REQ_FREE, 1'b0, 12'hFFF, 1'b1, 1'b0);
    // frees of frames that are already free, top of the range too, and of frame 0
    send_req(REQ_FREE, 1'b1, 12'hFFF, 1'b0, 1'b0);
    send_req(REQ_FREE, 1'b1, 12'h000, 1'b1, 1'b1);
    send_req(REQ_FREE, 1'b1, 12'h000, 1'b0, 1'b1);
    send_req(REQ_FREE, 1'b1, 12'hAAA, 1'b1, 1'b0);
    send_req(REQ_FREE, 1'b1, 12'h555, 1'b0, 1'b1);
    send_req(REQ_ALLOC, 1'b0, 12'h000, 1'b0, 1'b0);  // frame 0 again
    send_req(REQ_ALLOC, 1'b0, 12'hFFF, 1'b1, 1'b1);  // next hole

    // Churn in the low part of the map.
    for (int i = 0; i < 400; i++) send_random(55, 30, 255);

    // Allocation-heavy run: the map grows and the scan walks ever more
    // full words before it finds a hole.
    for (int i = 0; i < 600; i++) send_random(97, 0, FRAME_SPAN - 1);

    // Frees punch holes anywhere, allocs refill the lowest ones.
    for (int i = 0; i < 133; i++) send_random(45, 35, FRAME_SPAN - 1);

    req_ch.valid <= 1'b0;

    // drain, then allow one more worst-case scan
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (150) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
